[design/dls_pkg.sv]
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types and codes of the discrete level snapper: transaction payloads,
// command and status codes, and the handoff between sequencer and top level.
// ----------------------------------------------------------------------------
package dls_pkg;

   // Command codes carried in the request transaction.
   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_INSERT   = 2'd1;
   localparam logic [1:0] CMD_CORRECT  = 2'd2;
   localparam logic [1:0] CMD_VALIDATE = 2'd3;

   // Status codes carried in the response transaction.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_NOT_LEVEL = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   localparam int unsigned VALUE_W = 32;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [1:0]                status;
   } rsp_type;

   // Finished result offered by the sequencer to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } handoff_type;

endpackage

[design/discrete_level_snapper.sv]
// ----------------------------------------------------------------------------
// discrete_level_snapper
// Nearest-level quantizer over a sorted table of signed Q16.16 levels.
// ----------------------------------------------------------------------------
// Usage: a request transaction carries a command (clear, insert, correct,
// validate) and a Q16.16 operand; every request yields exactly one response
// transaction with a result value and a status code.
// Both channels use valid/ready; a transaction moves when both are high.
// Requests are handled one at a time. The level memory has a single read
// port and is walked one entry per cycle (shift-up for insert, scan for the
// others). The sequencer is ready for the next request in the cycle after
// the finished result moves into the output register, even if the receiver
// has not yet taken it.
// Reset (synchronous, active high) empties the table by zeroing the level
// count; the memory itself is not cleared and needs no clearing pass.
// A stalled receiver holds the response register; a finished result then
// waits in the sequencer and no further request is accepted until it moves.
// ----------------------------------------------------------------------------
module discrete_level_snapper
   import dls_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // The count must reach MAX_LEVELS itself; addresses only go up to one less.
   localparam int unsigned CNT_W  = $clog2(MAX_LEVELS + 1);
   localparam int unsigned ADDR_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   handoff_type               done;
   logic                      done_ready;
   logic                      mem_wr_en;
   logic [ADDR_W-1:0]         mem_wr_addr;
   logic signed [VALUE_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]         mem_rd_addr;
   logic signed [VALUE_W-1:0] mem_rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   dls_ctrl #(
      .MAX_LEVELS (MAX_LEVELS),
      .CNT_W      (CNT_W),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .done        (done),
      .done_ready  (done_ready),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   dls_level_ram #(
      .DEPTH  (MAX_LEVELS),
      .ADDR_W (ADDR_W)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: it can load whenever it is empty or being drained,
   // so the sequencer is released while the receiver is still deciding.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done.valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A request transaction keeps the sequencer busy in the cycle after it is accepted.
   a_req_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on two consecutive cycles");

   // The sequencer never takes a request while it still offers a result.
   a_idle_excludes_done: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !done.valid)
      else $error("sequencer ready while holding a finished result");

   // A finished result held back by the output register stays put.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done.valid && !done_ready |=> done.valid && $stable(done.rsp))
      else $error("finished result changed while waiting for the output register");
`endif

endmodule

[design/dls_level_ram.sv]
// ----------------------------------------------------------------------------
// dls_level_ram
// Level table storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dls_level_ram
   import dls_pkg::*;
#(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic signed [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/dls_ctrl.sv]
// ----------------------------------------------------------------------------
// dls_ctrl
// Command sequencer: holds the level count, walks the level table through
// the memory port for insert (shift up) and correct/validate (linear scan).
// ----------------------------------------------------------------------------
module dls_ctrl
   import dls_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = 16,
   parameter int unsigned CNT_W      = 5,
   parameter int unsigned ADDR_W     = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output handoff_type               done,
   input  logic                      done_ready,
   output logic                      mem_wr_en,
   output logic [ADDR_W-1:0]         mem_wr_addr,
   output logic signed [VALUE_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0]         mem_rd_addr,
   input  logic signed [VALUE_W-1:0] mem_rd_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_PUT    = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEVELS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] operand_ff, operand_in;
   logic [CNT_W-1:0]          hole_ff, hole_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic signed [VALUE_W-1:0] best_ff, best_in;
   logic [VALUE_W:0]          dist_ff, dist_in;
   logic                      found_ff, found_in;
   rsp_type                   res_ff, res_in;

   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W:0]          dist_cur;
   logic                      closer;
   logic signed [VALUE_W-1:0] best_nxt;
   logic                      found_nxt;
   logic [CNT_W-1:0]          hole_dec;
   logic [CNT_W-1:0]          hole_dec2;
   logic [CNT_W-1:0]          count_dec;

   // Distance of the entry coming out of the memory to the operand.
   assign diff      = {mem_rd_data[VALUE_W-1], mem_rd_data}
                      - {operand_ff[VALUE_W-1], operand_ff};
   assign dist_cur  = diff[VALUE_W] ? (VALUE_W+1)'(0) - diff : diff;
   assign closer    = dist_cur < dist_ff;
   assign best_nxt  = closer ? mem_rd_data : best_ff;
   assign found_nxt = found_ff | (mem_rd_data == operand_ff);

   assign hole_dec  = hole_ff - CNT_ONE;
   assign hole_dec2 = hole_ff - CNT_TWO;
   assign count_dec = count_ff - CNT_ONE;

   assign req_ready = (state_ff == S_IDLE);
   assign done      = '{valid: (state_ff == S_DONE), rsp: res_ff};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      operand_in  = operand_ff;
      hole_in     = hole_ff;
      rd_idx_in   = rd_idx_ff;
      best_in     = best_ff;
      dist_in     = dist_ff;
      found_in    = found_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = hole_ff[ADDR_W-1:0];
      mem_wr_data = operand_ff;
      mem_rd_addr = rd_idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               operand_in = req_data.operand;
               res_in     = '{result_value: req_data.operand, status: STAT_OK};
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  CMD_INSERT: begin
                     if (count_ff == CNT_MAX) begin
                        res_in.status = STAT_FULL;
                        state_in      = S_DONE;
                     end else if (count_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = req_data.operand;
                        count_in    = CNT_ONE;
                        state_in    = S_DONE;
                     end else begin
                        // Start at the top of the table and open a hole
                        // at the count position.
                        mem_rd_addr = count_dec[ADDR_W-1:0];
                        hole_in     = count_ff;
                        state_in    = S_SHIFT;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        mem_rd_addr = '0;
                        rd_idx_in   = CNT_ONE;
                        dist_in     = '1;
                        best_in     = '0;
                        found_in    = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Read data is the entry just below the hole.
            mem_wr_en   = 1'b1;
            mem_wr_addr = hole_ff[ADDR_W-1:0];
            if (mem_rd_data > operand_ff) begin
               mem_wr_data = mem_rd_data;
               mem_rd_addr = hole_dec2[ADDR_W-1:0];
               hole_in     = hole_dec;
               if (hole_ff == CNT_ONE) begin
                  state_in = S_PUT;
               end
            end else begin
               mem_wr_data = operand_ff;
               count_in    = count_ff + CNT_ONE;
               state_in    = S_DONE;
            end
         end

         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = operand_ff;
            count_in    = count_ff + CNT_ONE;
            state_in    = S_DONE;
         end

         S_SCAN: begin
            // Read data is entry rd_idx_ff - 1; the next read is issued now.
            mem_rd_addr = rd_idx_ff[ADDR_W-1:0];
            best_in     = best_nxt;
            dist_in     = closer ? dist_cur : dist_ff;
            found_in    = found_nxt;
            if (rd_idx_ff == count_ff) begin
               if (cmd_ff == CMD_CORRECT) begin
                  res_in.result_value = best_nxt;
               end else begin
                  res_in.status = found_nxt ? STAT_OK : STAT_NOT_LEVEL;
               end
               state_in = S_DONE;
            end else begin
               rd_idx_in = rd_idx_ff + CNT_ONE;
            end
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      operand_ff <= operand_in;
      hole_ff    <= hole_in;
      rd_idx_ff  <= rd_idx_in;
      best_ff    <= best_in;
      dist_ff    <= dist_in;
      found_ff   <= found_in;
      res_ff     <= res_in;
   end

endmodule

[tb/snapper_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snapper_scoreboard_pkg
// Response predictor and in-order checker for the discrete level snapper.
// ----------------------------------------------------------------------------
package snapper_scoreboard_pkg;
   import dls_pkg::*;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned REPORT_LIMIT = 10;

   class snapper_scoreboard;
      logic signed [VALUE_W-1:0] levels [TABLE_DEPTH];
      int unsigned level_count;
      rsp_type awaited_results [$];

      int unsigned mismatches;
      int unsigned responses_checked;
      int unsigned n_insert, n_full, n_correct, n_clamped, n_tie;
      int unsigned n_validate, n_miss, n_empty, n_clear;

      function new();
         level_count = 0;
         mismatches = 0;
         responses_checked = 0;
         n_insert = 0; n_full = 0; n_correct = 0; n_clamped = 0; n_tie = 0;
         n_validate = 0; n_miss = 0; n_empty = 0; n_clear = 0;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      // Works out the response of one request and advances the level table.
      function rsp_type predict_result(req_type r);
         rsp_type o;
         logic signed [VALUE_W-1:0] v;
         logic signed [VALUE_W-1:0] best;
         longint best_dist;
         longint d;
         int pos;
         v = r.operand;
         o.result_value = v;
         o.status = STAT_OK;
         case (r.cmd)
            CMD_CLEAR: begin
               level_count = 0;
               n_clear++;
            end
            CMD_INSERT: begin
               n_insert++;
               if (level_count >= TABLE_DEPTH) begin
                  o.status = STAT_FULL;
                  n_full++;
               end else begin
                  // Equal entries stay below the new one.
                  pos = level_count;
                  while (pos > 0 && levels[pos-1] > v) begin
                     levels[pos] = levels[pos-1];
                     pos--;
                  end
                  levels[pos] = v;
                  level_count++;
               end
            end
            CMD_CORRECT: begin
               n_correct++;
               if (level_count == 0) begin
                  o.status = STAT_EMPTY;
                  n_empty++;
               end else if (v < levels[0]) begin
                  o.result_value = levels[0];
                  n_clamped++;
               end else if (v > levels[level_count-1]) begin
                  o.result_value = levels[level_count-1];
                  n_clamped++;
               end else begin
                  best = levels[0];
                  best_dist = longint'(v) - longint'(levels[0]);
                  if (best_dist < 0) best_dist = -best_dist;
                  // Ascending scan with a strict compare keeps the lower level on a tie.
                  for (int i = 1; i < level_count; i++) begin
                     d = longint'(v) - longint'(levels[i]);
                     if (d < 0) d = -d;
                     if (d < best_dist) begin
                        best_dist = d;
                        best = levels[i];
                     end else if (d == best_dist && levels[i] != best) begin
                        n_tie++;
                     end
                  end
                  o.result_value = best;
               end
            end
            default: begin
               n_validate++;
               if (level_count == 0) begin
                  o.status = STAT_EMPTY;
                  n_empty++;
               end else begin
                  o.status = STAT_NOT_LEVEL;
                  for (int i = 0; i < level_count; i++)
                     if (levels[i] == v) o.status = STAT_OK;
                  if (o.status == STAT_NOT_LEVEL) n_miss++;
               end
            end
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         awaited_results.push_back(predict_result(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: unexpected response value %0d status %0d",
                        got.result_value, got.status);
            return;
         end
         want = awaited_results.pop_front();
         responses_checked++;
         if (got.result_value !== want.result_value || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: response %0d: value %0d (expected %0d), status %0d (expected %0d)",
                        responses_checked, got.result_value, want.result_value,
                        got.status, want.status);
         end
      endfunction

      function void summarize();
         $display("Checked %0d responses: %0d clears, %0d inserts (%0d on a full table), %0d corrections (%0d clamped, %0d ties)",
                  responses_checked, n_clear, n_insert, n_full, n_correct, n_clamped, n_tie);
         $display("%0d validations (%0d not a level), %0d commands on an empty table, %0d mismatches",
                  n_validate, n_miss, n_empty, mismatches);
      endfunction
   endclass

endpackage

[tb/tb_discrete_level_snapper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_discrete_level_snapper
// Self-checking bench for the discrete level snapper. Requests are driven
// through the valid/ready channel, every accepted request is predicted by a
// scoreboard, and each response is compared in order against the prediction.
// ----------------------------------------------------------------------------
module tb_discrete_level_snapper;
   import dls_pkg::*;
   import snapper_scoreboard_pkg::*;

   localparam int unsigned LEVEL_SLOTS  = 16;
   localparam int unsigned RANDOM_ITEMS = 2000;
   // The slowest correct run is roughly 2100 transactions, stretched a few
   // times over by stalls on either side.
   localparam int unsigned CYCLE_LIMIT  = 600000;
   // Longest request latency plus some slack for a stray response.
   localparam int unsigned TAIL_CYCLES  = LEVEL_SLOTS + 8;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] ONE     = 32'sh0001_0000;

   // Every input is known from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Percent chance per cycle that the sender or the receiver holds off.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count   = 0;
   int unsigned items_sent    = 0;

   // Stimulus-side copy of the inserted levels, used only to aim probe values
   // at and between stored levels. Checking uses the scoreboard alone.
   logic signed [VALUE_W-1:0] shadow_levels [$];

   snapper_scoreboard sb;

   discrete_level_snapper #(
      .MAX_LEVELS(LEVEL_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The receiver decides at each falling edge whether it takes a response
   // at the next rising edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Both channels are observed at the rising edge. A request is noted before
   // any response of the same edge is checked, although the block's latency
   // never lets a request and its own response meet on one edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly small values on a half-unit grid so that duplicates and exact
   // midpoints turn up often; the rest covers the full range and its edges.
   function automatic logic signed [VALUE_W-1:0] pick_level();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60) return (int'($urandom_range(40)) - 20) <<< 15;
      if (sel < 85) return $urandom;
      case ($urandom_range(3))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         default: return -1;
      endcase
   endfunction

   // Probe values for correct and validate: exact levels, midpoints between a
   // level and the next higher one (ties), near misses, and free values.
   function automatic logic signed [VALUE_W-1:0] pick_probe();
      logic signed [VALUE_W-1:0] a;
      logic signed [VALUE_W-1:0] b;
      longint sum;
      bit found;
      int unsigned sel;
      sel = $urandom_range(99);
      if (shadow_levels.size() == 0 || sel >= 85) return pick_level();
      a = shadow_levels[$urandom_range(shadow_levels.size() - 1)];
      if (sel < 30) return a;
      if (sel < 60) begin
         found = 1'b0;
         b = a;
         foreach (shadow_levels[i]) begin
            if (shadow_levels[i] > a && (!found || shadow_levels[i] < b)) begin
               b = shadow_levels[i];
               found = 1'b1;
            end
         end
         if (found) begin
            sum = longint'(a) + longint'(b);
            return VALUE_W'(sum >>> 1);
         end
      end
      return a + (int'($urandom_range(8)) - 4);
   endfunction

   // Presents one request at the falling edge and holds it until accepted.
   // A random idle stretch may come first; valid is lowered only then, so it
   // is never dropped and raised again within one time step.
   task automatic drive_request(input logic [1:0] cmd,
                                input logic signed [VALUE_W-1:0] operand);
      req_type item;
      int unsigned gap;
      item.cmd = cmd;
      item.operand = operand;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic issue(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] operand);
      case (cmd)
         CMD_CLEAR:  shadow_levels.delete();
         CMD_INSERT: if (shadow_levels.size() < LEVEL_SLOTS) shadow_levels.push_back(operand);
         default:    ;
      endcase
      drive_request(cmd, operand);
   endtask

   // The sender goes quiet until every predicted response has been taken.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Hand-picked cases: empty table, clamping at both ends, a tie, duplicate
   // levels, the extreme operands, and an insert into a full table.
   task automatic run_directed();
      issue(CMD_CLEAR,    32'sh1234_5678);
      issue(CMD_CORRECT,  32'sh1234_5678);
      issue(CMD_VALIDATE, VAL_MIN);
      issue(CMD_INSERT,   100 * ONE);
      issue(CMD_INSERT,   -100 * ONE);
      issue(CMD_INSERT,   100 * ONE);
      issue(CMD_CORRECT,  VAL_MIN);
      issue(CMD_CORRECT,  VAL_MAX);
      issue(CMD_CORRECT,  '0);
      issue(CMD_VALIDATE, 100 * ONE);
      issue(CMD_VALIDATE, 5);
      issue(CMD_INSERT,   VAL_MIN);
      issue(CMD_INSERT,   VAL_MAX);
      issue(CMD_VALIDATE, VAL_MAX);
      issue(CMD_CORRECT,  -1);
      while (shadow_levels.size() < LEVEL_SLOTS)
         issue(CMD_INSERT, shadow_levels.size() * (ONE >>> 1));
      issue(CMD_INSERT,   ONE);
      issue(CMD_CLEAR,    '0);
      issue(CMD_VALIDATE, '0);
   endtask

   // Occasional stray command with a free operand, which may also break the
   // sequence in progress by clearing the table.
   task automatic maybe_noise();
      if ($urandom_range(99) < 5) issue(2'($urandom_range(3)), $urandom);
   endtask

   // A well-formed sequence: usually a clear, a run of inserts that sometimes
   // overfills the table, then a series of corrections and validations.
   task automatic run_sequence();
      int unsigned inserts;
      int unsigned probes;
      if ($urandom_range(99) < 75) issue(CMD_CLEAR, pick_level());
      if ($urandom_range(99) < 25) inserts = $urandom_range(18, 14);
      else inserts = $urandom_range(10, 1);
      repeat (inserts) begin
         maybe_noise();
         issue(CMD_INSERT, pick_level());
      end
      probes = $urandom_range(12, 3);
      repeat (probes) begin
         maybe_noise();
         issue($urandom_range(1) ? CMD_CORRECT : CMD_VALIDATE, pick_probe());
      end
   endtask

   initial begin
      int unsigned target;
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Three idling phases: slow receiver, slow sender, then full speed.
      // Between phases the sender waits until every response is back.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 13; recv_idle_pct = 53; end
            1: begin send_idle_pct = 53; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 0) run_directed();
         target = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < target) run_sequence();
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      sb.summarize();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
